// ===== rtl/core/dmst_pkg.sv =====
// ----------------------------------------------------------------------------
// dmst_pkg
// Types and constants shared by the drive motor spin-down timer.
// ----------------------------------------------------------------------------
package dmst_pkg;

    localparam int unsigned TIME_W = 12;
    localparam int unsigned MASK_W = 4;

    // operation codes
    localparam logic [1:0] OP_ON   = 2'd0;
    localparam logic [1:0] OP_OFF  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // per-drive motor state codes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_WAIT = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_OFF_DELAY   = 3'd0;
    localparam logic [2:0] REG_TICK_PERIOD = 3'd1;
    localparam logic [2:0] REG_SPINUP_FAST = 3'd2;
    localparam logic [2:0] REG_SPINUP_SLOW = 3'd3;
    localparam logic [2:0] REG_FAST_MASK   = 3'd4;

    // configuration reset values
    localparam logic [TIME_W-1:0] RST_OFF_DELAY   = 12'd2500;
    localparam logic [TIME_W-1:0] RST_TICK_PERIOD = 12'd400;
    localparam logic [TIME_W-1:0] RST_SPINUP_FAST = 12'd300;
    localparam logic [TIME_W-1:0] RST_SPINUP_SLOW = 12'd500;
    localparam logic [MASK_W-1:0] RST_FAST_MASK   = 4'd0;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] drive;
    } t_in_word;

    typedef struct packed {
        logic [MASK_W-1:0] motor_enable;
        logic [TIME_W-1:0] spinup_wait_ms;
        logic [1:0]        drive_status;
        logic [MASK_W-1:0] stopped_mask;
    } t_out_word;

    // status of one drive after the current word
    typedef struct packed {
        logic [1:0] mode;
        logic       started;
        logic       stopped;
    } t_cell_stat;

endpackage

// ===== rtl/core/drive_motor_spin_timer.sv =====
// ----------------------------------------------------------------------------
// drive_motor_spin_timer
// Motor on/off state and spin-down countdown for a set of floppy drives.
// ----------------------------------------------------------------------------
// path: an accepted word waits in the input register, passes the drive cells and
// goes to the result register once that register is empty or being taken
// throughput: one word per cycle unless the result stalls, set by the single update
// pass of the drive cells; an input and a result register decouple the two sides
// reset: synchronous active low; all motors off, countdowns zero, config at defaults
module drive_motor_spin_timer #(
    parameter int DRIVE_COUNT = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  dmst_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dmst_pkg::t_out_word         o_out_word,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [2:0]                  i_cfg_index,
    input  logic [dmst_pkg::TIME_W-1:0] i_cfg_data
);
    import dmst_pkg::*;

    localparam int LOW_N = (DRIVE_COUNT < MASK_W) ? DRIVE_COUNT : MASK_W;

    logic [TIME_W-1:0] r_off_delay;
    logic [TIME_W-1:0] r_tick_period;
    logic [TIME_W-1:0] r_spinup_fast;
    logic [TIME_W-1:0] r_spinup_slow;
    logic [MASK_W-1:0] r_fast_mask;

    logic              r_s1_valid;
    t_in_word          r_in;
    logic              r_out_valid;
    t_out_word         r_out;
    t_out_word         n_out;

    logic              w_in_accept;
    logic              w_advance;
    logic              w_drive_ok;

    t_cell_stat            w_stat [DRIVE_COUNT];
    logic [DRIVE_COUNT-1:0] w_en;
    logic [DRIVE_COUNT-1:0] w_stop;
    logic [DRIVE_COUNT-1:0] w_start;
    logic [1:0]             w_status;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_delay   <= RST_OFF_DELAY;
            r_tick_period <= RST_TICK_PERIOD;
            r_spinup_fast <= RST_SPINUP_FAST;
            r_spinup_slow <= RST_SPINUP_SLOW;
            r_fast_mask   <= RST_FAST_MASK;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OFF_DELAY:   r_off_delay   <= i_cfg_data;
                REG_TICK_PERIOD: r_tick_period <= i_cfg_data;
                REG_SPINUP_FAST: r_spinup_fast <= i_cfg_data;
                REG_SPINUP_SLOW: r_spinup_slow <= i_cfg_data;
                REG_FAST_MASK:   r_fast_mask   <= i_cfg_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake and pipeline control
    assign w_advance   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_advance;
    assign w_in_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= i_in_word;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign w_drive_ok = int'(r_in.drive) < DRIVE_COUNT;

    // one cell per drive
    for (genvar g = 0; g < DRIVE_COUNT; g++) begin : g_drive
        logic w_sel;
        assign w_sel = (int'(r_in.drive) == g);

        dmst_drive_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_step        (w_advance),
            .i_op          (r_in.operation),
            .i_sel         (w_sel),
            .i_off_delay   (r_off_delay),
            .i_tick_period (r_tick_period),
            .o_stat        (w_stat[g])
        );

        assign w_en[g]    = (w_stat[g].mode != MODE_OFF);
        assign w_stop[g]  = w_stat[g].stopped;
        assign w_start[g] = w_stat[g].started;
    end

    always_comb begin
        w_status = MODE_OFF;
        for (int d = 0; d < DRIVE_COUNT; d++) begin
            if (int'(r_in.drive) == d) begin
                w_status = w_stat[d].mode;
            end
        end
    end

    always_comb begin
        n_out                = '0;
        n_out.motor_enable   = MASK_W'(w_en[LOW_N-1:0]);
        n_out.stopped_mask   = MASK_W'(w_stop[LOW_N-1:0]);
        n_out.drive_status   = w_drive_ok ? w_status : MODE_OFF;
        // only the addressed drive can start, and it is always below four
        if (|w_start) begin
            n_out.spinup_wait_ms = r_fast_mask[r_in.drive] ? r_spinup_fast : r_spinup_slow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_stop_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in.operation != OP_TICK |=> o_out_word.stopped_mask == '0)
        else $error("stopped drives reported on a word that is not a tick");

    a_wait_means_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.spinup_wait_ms != '0 |->
            o_out_word.drive_status == MODE_ON)
        else $error("spin-up wait reported for a drive that is not on");

    a_stopped_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.stopped_mask & o_out_word.motor_enable) == '0)
        else $error("stopped drive still has its enable bit set");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");
`endif

endmodule

// ===== rtl/core/dmst_drive_cell.sv =====
// ----------------------------------------------------------------------------
// dmst_drive_cell
// Mode and spin-down countdown of one drive motor.
// ----------------------------------------------------------------------------
module dmst_drive_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [1:0]                  i_op,
    input  logic                        i_sel,
    input  logic [dmst_pkg::TIME_W-1:0] i_off_delay,
    input  logic [dmst_pkg::TIME_W-1:0] i_tick_period,
    output dmst_pkg::t_cell_stat        o_stat
);
    import dmst_pkg::*;

    logic [1:0]        r_mode;
    logic [1:0]        n_mode;
    logic [TIME_W-1:0] r_count;
    logic [TIME_W-1:0] n_count;
    logic              w_started;
    logic              w_stopped;

    always_comb begin
        n_mode    = r_mode;
        n_count   = r_count;
        w_started = 1'b0;
        w_stopped = 1'b0;
        case (i_op)
            OP_ON: begin
                if (i_sel && r_mode == MODE_OFF) begin
                    n_mode    = MODE_ON;
                    w_started = 1'b1;
                end else if (i_sel && r_mode == MODE_WAIT) begin
                    n_mode = MODE_ON;
                end
            end
            OP_OFF: begin
                if (i_sel && r_mode == MODE_ON) begin
                    n_mode  = MODE_WAIT;
                    n_count = i_off_delay;
                end
            end
            OP_TICK: begin
                if (r_mode == MODE_WAIT) begin
                    // countdown at or below one period runs out on this tick
                    if (r_count <= i_tick_period) begin
                        n_count   = '0;
                        n_mode    = MODE_OFF;
                        w_stopped = 1'b1;
                    end else begin
                        n_count = r_count - i_tick_period;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_OFF;
            r_count <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    assign o_stat.mode    = n_mode;
    assign o_stat.started = w_started;
    assign o_stat.stopped = w_stopped;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for drive_motor_spin_timer: a directed table of
// motor requests and ticks, then random phases under changing register
// settings and idle patterns, every result word checked against its
// table value or an in-bench model of the four drive state machines.
// ----------------------------------------------------------------------------
module tb;
    import dmst_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned SETTLE       = 4;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_WORDS  = 105;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRIVES       = 4;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] REG_SPARE = 3'd5;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [11:0] data;
        t_in_word    word;
        bit          typed;
        t_out_word   want;
    } t_row;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_ready;
    t_out_word   out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    // model state and registers
    logic [1:0]  drv_mode  [DRIVES];
    logic [11:0] drv_count [DRIVES];
    logic [11:0] off_delay;
    logic [11:0] tick_period;
    logic [11:0] spin_fast;
    logic [11:0] spin_slow;
    logic [3:0]  fast_mask;

    t_out_word expected_words [$];
    t_row      plan [$];
    int        mismatches;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_req;

    drive_motor_spin_timer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_out_word spin_timer_step(t_in_word w);
        t_out_word r;
        r = '0;
        case (w.operation)
            OP_ON: begin
                if (drv_mode[w.drive] == MODE_OFF) begin
                    drv_mode[w.drive] = MODE_ON;
                    r.spinup_wait_ms = fast_mask[w.drive] ? spin_fast : spin_slow;
                end else if (drv_mode[w.drive] == MODE_WAIT) begin
                    drv_mode[w.drive] = MODE_ON;
                end
            end
            OP_OFF: begin
                if (drv_mode[w.drive] == MODE_ON) begin
                    drv_mode[w.drive]  = MODE_WAIT;
                    drv_count[w.drive] = off_delay;
                end
            end
            OP_TICK: begin
                for (int d = 0; d < DRIVES; d++) begin
                    if (drv_mode[d] == MODE_WAIT) begin
                        if (drv_count[d] <= tick_period) begin
                            drv_count[d]      = '0;
                            drv_mode[d]       = MODE_OFF;
                            r.stopped_mask[d] = 1'b1;
                        end else begin
                            drv_count[d] = drv_count[d] - tick_period;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.drive_status = drv_mode[w.drive];
        for (int d = 0; d < DRIVES; d++)
            r.motor_enable[d] = (drv_mode[d] != MODE_OFF);
        return r;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [11:0] data);
        case (idx)
            REG_OFF_DELAY:   off_delay   = data;
            REG_TICK_PERIOD: tick_period = data;
            REG_SPINUP_FAST: spin_fast   = data;
            REG_SPINUP_SLOW: spin_slow   = data;
            REG_FAST_MASK:   fast_mask   = data[3:0];
            default: ;
        endcase
    endfunction

    function automatic t_row plan_word(logic [1:0] op, logic [1:0] drv);
        t_row r;
        r.kind = ROW_WORD;
        r.idx = '0;
        r.data = '0;
        r.word.operation = op;
        r.word.drive = drv;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic t_row plan_check(logic [1:0] op, logic [1:0] drv, logic [3:0] en,
                                        logic [11:0] wait_ms, logic [1:0] st,
                                        logic [3:0] stop);
        t_row r;
        r = plan_word(op, drv);
        r.typed = 1'b1;
        r.want.motor_enable = en;
        r.want.spinup_wait_ms = wait_ms;
        r.want.drive_status = st;
        r.want.stopped_mask = stop;
        return r;
    endfunction

    function automatic t_row plan_cfg(logic [2:0] idx, logic [11:0] data);
        t_row r;
        r = plan_word(OP_UNUSED, 2'd0);
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [11:0] pick_time(logic [11:0] floor_ms);
        case ($urandom_range(3))
            0: return floor_ms;
            1: return 12'hfff;
            2: return floor_ms + 12'($urandom_range(600));
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        t_out_word pred;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        pred = spin_timer_step(w);
        expected_words.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                flag_mismatch("word with none expected", int'(out_word), 0);
            end else begin
                want = expected_words.pop_front();
                if (out_word.motor_enable !== want.motor_enable)
                    flag_mismatch("motor_enable", int'(out_word.motor_enable),
                                  int'(want.motor_enable));
                if (out_word.spinup_wait_ms !== want.spinup_wait_ms)
                    flag_mismatch("spinup_wait_ms", int'(out_word.spinup_wait_ms),
                                  int'(want.spinup_wait_ms));
                if (out_word.drive_status !== want.drive_status)
                    flag_mismatch("drive_status", int'(out_word.drive_status),
                                  int'(want.drive_status));
                if (out_word.stopped_mask !== want.stopped_mask)
                    flag_mismatch("stopped_mask", int'(out_word.stopped_mask),
                                  int'(want.stopped_mask));
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        t_in_word   w;
        int         r;
        int         drain;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_word        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        off_delay      = RST_OFF_DELAY;
        tick_period    = RST_TICK_PERIOD;
        spin_fast      = RST_SPINUP_FAST;
        spin_slow      = RST_SPINUP_SLOW;
        fast_mask      = RST_FAST_MASK;
        for (int d = 0; d < DRIVES; d++) begin
            drv_mode[d]  = MODE_OFF;
            drv_count[d] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults after reset
        plan.push_back(plan_check(OP_TICK, 2'd0, 4'b0000, 12'd0, MODE_OFF, 4'b0000));
        plan.push_back(plan_check(OP_ON, 2'd0, 4'b0001, 12'd500, MODE_ON, 4'b0000));
        plan.push_back(plan_check(OP_ON, 2'd0, 4'b0001, 12'd0, MODE_ON, 4'b0000));
        plan.push_back(plan_check(OP_OFF, 2'd1, 4'b0001, 12'd0, MODE_OFF, 4'b0000));
        plan.push_back(plan_check(OP_ON, 2'd3, 4'b1001, 12'd500, MODE_ON, 4'b0000));
        plan.push_back(plan_check(OP_OFF, 2'd0, 4'b1001, 12'd0, MODE_WAIT, 4'b0000));
        plan.push_back(plan_check(OP_OFF, 2'd0, 4'b1001, 12'd0, MODE_WAIT, 4'b0000));
        plan.push_back(plan_word(OP_TICK, 2'd2));
        // on while waiting: back to on with no spin-up wait
        plan.push_back(plan_check(OP_ON, 2'd0, 4'b1001, 12'd0, MODE_ON, 4'b0000));
        plan.push_back(plan_word(OP_OFF, 2'd0));
        plan.push_back(plan_check(OP_UNUSED, 2'd2, 4'b1001, 12'd0, MODE_OFF, 4'b0000));
        plan.push_back(plan_word(OP_UNUSED, 2'd3));
        // 2500 ms at 400 per tick runs out on the seventh tick
        for (int i = 0; i < 6; i++)
            plan.push_back(plan_word(OP_TICK, 2'd0));
        plan.push_back(plan_check(OP_TICK, 2'd0, 4'b1000, 12'd0, MODE_OFF, 4'b0001));
        // extremes: zero off delay, full spin-up wait
        plan.push_back(plan_cfg(REG_OFF_DELAY, 12'd0));
        plan.push_back(plan_cfg(REG_TICK_PERIOD, 12'hfff));
        plan.push_back(plan_cfg(REG_SPINUP_FAST, 12'hfff));
        plan.push_back(plan_cfg(REG_SPINUP_SLOW, 12'd0));
        plan.push_back(plan_cfg(REG_FAST_MASK, 12'h005));
        plan.push_back(plan_check(OP_ON, 2'd2, 4'b1100, 12'hfff, MODE_ON, 4'b0000));
        plan.push_back(plan_check(OP_ON, 2'd1, 4'b1110, 12'd0, MODE_ON, 4'b0000));
        plan.push_back(plan_check(OP_OFF, 2'd1, 4'b1110, 12'd0, MODE_WAIT, 4'b0000));
        plan.push_back(plan_check(OP_TICK, 2'd1, 4'b1100, 12'd0, MODE_OFF, 4'b0010));
        // zero tick period: counts hold, only an expired count switches off
        plan.push_back(plan_cfg(REG_TICK_PERIOD, 12'd0));
        plan.push_back(plan_cfg(REG_OFF_DELAY, 12'hfff));
        plan.push_back(plan_word(OP_OFF, 2'd2));
        plan.push_back(plan_word(OP_OFF, 2'd3));
        plan.push_back(plan_check(OP_TICK, 2'd3, 4'b1100, 12'd0, MODE_WAIT, 4'b0000));
        plan.push_back(plan_cfg(REG_OFF_DELAY, 12'd0));
        plan.push_back(plan_word(OP_ON, 2'd3));
        plan.push_back(plan_word(OP_OFF, 2'd3));
        plan.push_back(plan_check(OP_TICK, 2'd3, 4'b0100, 12'd0, MODE_OFF, 4'b1000));
        // unit tick period, fast mask upper bits and a spare index ignored
        plan.push_back(plan_cfg(REG_TICK_PERIOD, 12'd1));
        plan.push_back(plan_cfg(REG_OFF_DELAY, 12'hfff));
        plan.push_back(plan_cfg(REG_SPINUP_FAST, 12'd0));
        plan.push_back(plan_cfg(REG_FAST_MASK, 12'hffa));
        plan.push_back(plan_cfg(REG_SPARE, 12'hfff));
        plan.push_back(plan_word(OP_TICK, 2'd2));
        plan.push_back(plan_word(OP_ON, 2'd1));
        plan.push_back(plan_word(OP_ON, 2'd0));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_word(plan[i].word, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_OFF_DELAY, pick_time(12'd0));
            write_reg(REG_TICK_PERIOD, pick_time(12'd1));
            write_reg(REG_SPINUP_FAST, pick_time(12'd0));
            write_reg(REG_SPINUP_SLOW, pick_time(12'd0));
            write_reg(REG_FAST_MASK, 12'($urandom_range(4095)));
            write_reg(REG_SPARE + 3'($urandom_range(2)), 12'($urandom_range(4095)));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            // long receiver hold-off while words keep coming: block fills up
            if (p == 4)
                hold_req = 1'b1;
            repeat (PHASE_WORDS) begin
                r = $urandom_range(99);
                if (r < 35)
                    w.operation = OP_ON;
                else if (r < 65)
                    w.operation = OP_OFF;
                else if (r < 95)
                    w.operation = OP_TICK;
                else
                    w.operation = OP_UNUSED;
                w.drive = 2'($urandom_range(3));
                send_word(w, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        drain = 0;
        while (expected_words.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge clk);
            drain++;
        end
        if (expected_words.size() != 0)
            flag_mismatch("words never delivered", expected_words.size(), 0);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
